// ===== hdl/impq_pkg.sv =====
// Shared types, constants and the entry ordering function for the indexed min-priority queue.
`default_nettype none

package impq_pkg;

   // sizing
   localparam int MAX_ENTRIES = 64;
   localparam int KEY_BITS    = 16;
   localparam int KEY_W       = 16;
   localparam int IDENT_W     = 6;
   localparam int IDENT_SPACE = 64;
   localparam int OCC_W       = 7;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;

   // one queue entry held by a cell
   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key;
      logic [IDENT_W-1:0]  ident;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{valid: 1'b0, key: '0, ident: '0};

   // operation broadcast to the cell row
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE,
      OP_POP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [KEY_BITS-1:0] key;
      logic [IDENT_W-1:0]  ident;
   } ctl_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // a orders before b: smaller key, ties broken by lower identifier
   function automatic logic before_fn(input logic [KEY_BITS-1:0] ka,
                                      input logic [IDENT_W-1:0]  ia,
                                      input logic [KEY_BITS-1:0] kb,
                                      input logic [IDENT_W-1:0]  ib);
      return (ka < kb) || ((ka == kb) && (ia < ib));
   endfunction

endpackage

`default_nettype wire

// ===== hdl/impq_cell.sv =====
// One cell of the sorted entry row: holds an entry and shifts with its neighbors.
`default_nettype none

module impq_cell import impq_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire ctl_type   ctl,
   input  wire entry_type left_entry,
   input  wire logic      left_flag,
   input  wire entry_type right_entry,
   output entry_type      entry_q,
   output logic           flag
);

   entry_type entry_ff;
   entry_type entry_in;

   // broadcast word orders before this entry (empty cells act as +infinity)
   assign flag = !entry_ff.valid ||
                 before_fn(ctl.key, ctl.ident, entry_ff.key, entry_ff.ident);

   // next entry
   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         OP_INSERT: begin
            // everything at or after the insert point moves right by one
            if (left_flag) begin
               entry_in = left_entry;
            end else if (flag) begin
               entry_in = '{valid: 1'b1, key: ctl.key, ident: ctl.ident};
            end
         end
         OP_REMOVE: begin
            // the target and all entries after it move left by one
            if (flag || (entry_ff.valid && (entry_ff.ident == ctl.ident))) begin
               entry_in = right_entry;
            end
         end
         OP_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_q = entry_ff;

endmodule

`default_nettype wire

// ===== hdl/indexed_min_priority_queue_core.sv =====
// Top level: command control, key lookup RAM, presence bits and the sorted cell row.
// The result strobe is registered: an accepted command enters the execute state, which
// registers the result word. Busy is high in the cycle after acceptance, so a new command
// is taken only after the registered key lookup RAM read and one update of the cell row.
// Reset (synchronous, active high) clears the cell valid bits, presence bits and count;
// the result strobe is a single cycle and the receiver cannot stall.
`default_nettype none

module indexed_min_priority_queue_core import impq_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [KEY_W-1:0]   req_key_in,
   input  wire logic [IDENT_W-1:0] req_ident_in,
   output logic                    rsp_valid,
   output logic [KEY_W-1:0]        rsp_key_out,
   output logic [IDENT_W-1:0]      rsp_ident_out,
   output logic                    rsp_is_empty,
   output logic [OCC_W-1:0]        rsp_occupancy,
   output logic                    rsp_error
);

   state_type           state_ff, state_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [IDENT_W-1:0]  ident_ff, ident_in;
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                present_ff [IDENT_SPACE];
   logic                present_in [IDENT_SPACE];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [IDENT_W-1:0]  rsp_ident_ff, rsp_ident_in;
   logic                rsp_error_ff, rsp_error_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic [KEY_BITS-1:0] key_mem [IDENT_SPACE];
   logic                accept;
   logic                mem_we;
   ctl_type             ctl;
   entry_type           cells_q [MAX_ENTRIES];
   logic                flags [MAX_ENTRIES];

   assign accept = start && !busy;

   // key of each identifier, looked up when a command is accepted
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[ident_ff] <= key_ff;
      end
      if (accept) begin
         rd_key_ff <= key_mem[req_ident_in];
      end
   end

   // sorted row of cells, head at index zero
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_flag;

      if (g == 0) begin : g_head
         assign left_entry = EMPTY_ENTRY;
         assign left_flag  = 1'b0;
      end else begin : g_body
         assign left_entry = cells_q[g-1];
         assign left_flag  = flags[g-1];
      end

      if (g == MAX_ENTRIES - 1) begin : g_tail
         assign right_entry = EMPTY_ENTRY;
      end else begin : g_inner
         assign right_entry = cells_q[g+1];
      end

      impq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .left_flag   (left_flag),
         .right_entry (right_entry),
         .entry_q     (cells_q[g]),
         .flag        (flags[g])
      );
   end

   // next state, cell operation and result word
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      ident_in     = ident_ff;
      count_in     = count_ff;
      present_in   = present_ff;
      rsp_valid_in = 1'b0;
      rsp_key_in   = rsp_key_ff;
      rsp_ident_in = rsp_ident_ff;
      rsp_error_in = rsp_error_ff;
      rsp_count_in = rsp_count_ff;
      mem_we       = 1'b0;
      ctl          = '{op: OP_HOLD, key: key_ff, ident: ident_ff};
      busy         = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd_in   = req_cmd;
               key_in   = KEY_BITS'(req_key_in);
               ident_in = req_ident_in;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = '0;
            rsp_ident_in = '0;
            rsp_error_in = 1'b0;
            state_in     = ST_IDLE;
            case (cmd_ff)
               CMD_INSERT: begin
                  if ((count_ff == CNT_W'(MAX_ENTRIES)) || present_ff[ident_ff]) begin
                     rsp_error_in = 1'b1;
                  end else begin
                     ctl                  = '{op: OP_INSERT, key: key_ff, ident: ident_ff};
                     mem_we               = 1'b1;
                     present_in[ident_ff] = 1'b1;
                     count_in             = count_ff + 1'b1;
                  end
               end
               CMD_REMOVE: begin
                  if (!present_ff[ident_ff]) begin
                     rsp_error_in = 1'b1;
                  end else begin
                     ctl                  = '{op: OP_REMOVE, key: rd_key_ff, ident: ident_ff};
                     present_in[ident_ff] = 1'b0;
                     count_in             = count_ff - 1'b1;
                     rsp_key_in           = KEY_W'(rd_key_ff);
                     rsp_ident_in         = ident_ff;
                  end
               end
               CMD_POP: begin
                  if (count_ff == '0) begin
                     rsp_error_in = 1'b1;
                  end else begin
                     ctl                          = '{op: OP_POP, key: key_ff, ident: ident_ff};
                     present_in[cells_q[0].ident] = 1'b0;
                     count_in                     = count_ff - 1'b1;
                     rsp_key_in                   = KEY_W'(cells_q[0].key);
                     rsp_ident_in                 = cells_q[0].ident;
                  end
               end
               default: begin
                  rsp_error_in = 1'b1;
               end
            endcase
            rsp_count_in = count_in;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < IDENT_SPACE; i++) begin
            present_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         present_ff   <= present_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      ident_ff     <= ident_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_ident_ff <= rsp_ident_in;
      rsp_error_ff <= rsp_error_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_ident_out = rsp_ident_ff;
   assign rsp_error     = rsp_error_ff;
   assign rsp_is_empty  = (rsp_count_ff == '0);
   assign rsp_occupancy = OCC_W'(rsp_count_ff);

endmodule

`default_nettype wire

// ===== hdl/impq_checker.sv =====
// Port-level checks for the queue core and the bind that attaches them.
`default_nettype none

module impq_checker import impq_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic [KEY_W-1:0]   rsp_key_out,
   input wire logic [IDENT_W-1:0] rsp_ident_out,
   input wire logic               rsp_is_empty,
   input wire logic [OCC_W-1:0]   rsp_occupancy,
   input wire logic               rsp_error
);

   logic accept;
   assign accept = start && !busy;

   // every accepted command is followed by its result word
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("result word missing two cycles after command");

   // busy covers the command in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy low right after acceptance");

   // strobe lasts one cycle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // empty flag agrees with occupancy
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_occupancy == '0)))
      else $error("empty flag disagrees with occupancy");

   // rejected command returns no entry
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> ((rsp_key_out == '0) && (rsp_ident_out == '0)))
      else $error("rejected command returned an entry");

endmodule

bind indexed_min_priority_queue_core impq_checker u_impq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_key_out   (rsp_key_out),
   .rsp_ident_out (rsp_ident_out),
   .rsp_is_empty  (rsp_is_empty),
   .rsp_occupancy (rsp_occupancy),
   .rsp_error     (rsp_error)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the indexed min-priority queue core.
`timescale 1ns / 1ps

module tb_top import impq_pkg::*; ;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 2000;

   // one result word as seen on the rsp_ ports
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [IDENT_W-1:0] ident;
      logic               empty;
      logic [OCC_W-1:0]   occ;
      logic               err;
   } qresult_type;

   // tracks queue contents and the results still owed by the block
   class queue_tracker;
      logic [KEY_W-1:0] key_of_ident [IDENT_SPACE];
      bit               present [IDENT_SPACE];
      int               count;
      qresult_type      owed_results [$];
      int               failures;
      int               n_insert, n_remove, n_pop, n_rejected, n_checked, peak;

      function new();
         count = 0;
         failures = 0;
         n_insert = 0;
         n_remove = 0;
         n_pop = 0;
         n_rejected = 0;
         n_checked = 0;
         peak = 0;
         foreach (present[i]) begin
            present[i] = 1'b0;
            key_of_ident[i] = '0;
         end
      endfunction

      // predict the result of one accepted command word
      function void note_command(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                 logic [IDENT_W-1:0] ident);
         qresult_type r;
         int best;
         r = '0;
         best = -1;
         case (cmd)
            CMD_INSERT: begin
               if (count >= MAX_ENTRIES || present[ident]) begin
                  r.err = 1'b1;
               end else begin
                  present[ident] = 1'b1;
                  key_of_ident[ident] = key;
                  count++;
                  n_insert++;
               end
            end
            CMD_REMOVE: begin
               if (!present[ident]) begin
                  r.err = 1'b1;
               end else begin
                  r.key = key_of_ident[ident];
                  r.ident = ident;
                  present[ident] = 1'b0;
                  count--;
                  n_remove++;
               end
            end
            CMD_POP: begin
               if (count == 0) begin
                  r.err = 1'b1;
               end else begin
                  // ascending scan with strict compare keeps the lower ident on ties
                  for (int i = 0; i < IDENT_SPACE; i++) begin
                     if (present[i] && (best < 0 || key_of_ident[i] < key_of_ident[best]))
                        best = i;
                  end
                  r.key = key_of_ident[best];
                  r.ident = best[IDENT_W-1:0];
                  present[best] = 1'b0;
                  count--;
                  n_pop++;
               end
            end
            default: r.err = 1'b1;
         endcase
         if (r.err)
            n_rejected++;
         if (count > peak)
            peak = count;
         r.empty = (count == 0);
         r.occ = count[OCC_W-1:0];
         owed_results.push_back(r);
      endfunction

      function bit field_ok(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      // compare one result word with the oldest prediction
      function void check_result(qresult_type got);
         qresult_type want;
         bit ok;
         if (owed_results.size() == 0) begin
            $error("result word with no prediction pending");
            failures++;
            return;
         end
         want = owed_results.pop_front();
         n_checked++;
         ok = field_ok("key_out", want.key, got.key);
         ok &= field_ok("ident_out", KEY_W'(want.ident), KEY_W'(got.ident));
         ok &= field_ok("is_empty", KEY_W'(want.empty), KEY_W'(got.empty));
         ok &= field_ok("occupancy", KEY_W'(want.occ), KEY_W'(got.occ));
         ok &= field_ok("error", KEY_W'(want.err), KEY_W'(got.err));
         if (!ok)
            failures++;
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd = CMD_INSERT;
   logic [KEY_W-1:0]   req_key_in = '0;
   logic [IDENT_W-1:0] req_ident_in = '0;
   logic               rsp_valid;
   logic [KEY_W-1:0]   rsp_key_out;
   logic [IDENT_W-1:0] rsp_ident_out;
   logic               rsp_is_empty;
   logic [OCC_W-1:0]   rsp_occupancy;
   logic               rsp_error;

   queue_tracker tracker = new();
   int           items_sent = 0;

   indexed_min_priority_queue_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_key_in    (req_key_in),
      .req_ident_in  (req_ident_in),
      .rsp_valid     (rsp_valid),
      .rsp_key_out   (rsp_key_out),
      .rsp_ident_out (rsp_ident_out),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_occupancy (rsp_occupancy),
      .rsp_error     (rsp_error)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result monitor: strobe is one cycle, sampled at the edge that ends it
   always @(posedge clock) begin : rsp_monitor
      qresult_type got;
      if (!reset && rsp_valid) begin
         got.key = rsp_key_out;
         got.ident = rsp_ident_out;
         got.empty = rsp_is_empty;
         got.occ = rsp_occupancy;
         got.err = rsp_error;
         tracker.check_result(got);
      end
   end

   // present a command word and hold it until the block takes it
   task automatic send_command(logic [1:0] cmd, logic [KEY_W-1:0] key,
                               logic [IDENT_W-1:0] ident);
      req_cmd <= cmd;
      req_key_in <= key;
      req_ident_in <= ident;
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      tracker.note_command(cmd, key, ident);
      items_sent++;
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold off the sender until every predicted word has come back
   task automatic drain_queue();
      start <= 1'b0;
      do
         @(posedge clock);
      while (tracker.owed_results.size() != 0);
   endtask

   // gap style 0 means back-to-back words
   function automatic int gap_len(int style);
      int r;
      r = $urandom_range(99);
      if (style == 0 || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // keys lean toward extremes and a narrow band to force ties
   function automatic logic [KEY_W-1:0] random_key();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3: return KEY_W'($urandom_range(7));
         4: return KEY_W'(16'h8000 + $urandom_range(3));
         default: return KEY_W'($urandom);
      endcase
   endfunction

   function automatic logic [IDENT_W-1:0] pick_ident(bit want_present);
      int ids [$];
      for (int i = 0; i < IDENT_SPACE; i++)
         if (tracker.present[i] == want_present)
            ids.push_back(i);
      if (ids.size() == 0)
         return IDENT_W'($urandom_range(IDENT_SPACE - 1));
      return IDENT_W'(ids[$urandom_range(ids.size() - 1)]);
   endfunction

   // one random word; mode sets the mix: fill, drain, balanced, noise
   task automatic random_command(int mode);
      int r;
      bit tidy;
      logic [1:0] cmd;
      r = $urandom_range(99);
      tidy = ($urandom_range(99) < 85);
      case (mode)
         0: cmd = (r < 95) ? CMD_INSERT : CMD_POP;
         1: cmd = (r < 50) ? CMD_POP : (r < 90) ? CMD_REMOVE : CMD_INSERT;
         2: cmd = (r < 45) ? CMD_INSERT : (r < 70) ? CMD_REMOVE :
                  (r < 95) ? CMD_POP : CMD_UNUSED;
         default: begin
            cmd = 2'($urandom_range(3));
            tidy = 1'b0;
         end
      endcase
      if (!tidy)
         send_command(cmd, KEY_W'($urandom), IDENT_W'($urandom_range(IDENT_SPACE - 1)));
      else if (cmd == CMD_INSERT)
         send_command(cmd, random_key(), pick_ident(1'b0));
      else if (cmd == CMD_REMOVE)
         send_command(cmd, KEY_W'($urandom), pick_ident(1'b1));
      else
         send_command(cmd, KEY_W'($urandom), IDENT_W'($urandom_range(IDENT_SPACE - 1)));
   endtask

   // main stimulus
   initial begin : stimulus
      int seg_len, mode, style;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: errors on empty, ties, key bit patterns, duplicate, unused code
      send_command(CMD_POP, 16'h0000, 6'd0);
      send_command(CMD_REMOVE, 16'h0000, 6'd9);
      send_command(CMD_UNUSED, 16'hFFFF, 6'd63);
      send_command(CMD_INSERT, 16'h0000, 6'd63);
      send_command(CMD_INSERT, 16'hFFFF, 6'd0);
      send_command(CMD_INSERT, 16'h0000, 6'd5);
      send_command(CMD_INSERT, 16'h1234, 6'd63);
      send_command(CMD_INSERT, 16'h8000, 6'd40);
      send_command(CMD_INSERT, 16'h7FFF, 6'd41);
      send_command(CMD_INSERT, 16'hAAAA, 6'd42);
      send_command(CMD_INSERT, 16'h5555, 6'd43);
      send_command(CMD_INSERT, 16'h5555, 6'd21);
      send_command(CMD_REMOVE, 16'h0000, 6'd0);
      send_command(CMD_REMOVE, 16'h0000, 6'd0);
      send_command(CMD_UNUSED, 16'h0000, 6'd0);
      send_command(CMD_REMOVE, 16'h0000, 6'd40);
      repeat (6) send_command(CMD_POP, 16'h0000, 6'd0);
      send_command(CMD_POP, 16'h0000, 6'd0);
      drain_queue();

      // random: first segment fills the queue to capacity and beyond
      mode = 0;
      seg_len = 110;
      style = 0;
      while (items_sent < ITEM_TARGET) begin
         for (int i = 0; i < seg_len && items_sent < ITEM_TARGET; i++) begin
            random_command(mode);
            idle_cycles(gap_len(style));
         end
         if ($urandom_range(2) == 0)
            drain_queue();
         mode = $urandom_range(3);
         seg_len = $urandom_range(40, 200);
         style = $urandom_range(2);
      end

      // wind down
      drain_queue();
      repeat (8) @(posedge clock);
      if (tracker.owed_results.size() != 0) begin
         $error("%0d predicted words never came back", tracker.owed_results.size());
         tracker.failures++;
      end
      $display("Checked %0d words: %0d inserts, %0d removes, %0d pops, %0d rejected.",
               tracker.n_checked, tracker.n_insert, tracker.n_remove, tracker.n_pop,
               tracker.n_rejected);
      $display("Peak occupancy %0d of %0d entries.", tracker.peak, MAX_ENTRIES);
      if (tracker.failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
